/* design/asc2i_pkg.sv */
`default_nettype none

package asc2i_pkg;

    // Field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned RADIX_W = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CNT_W   = 12;

    // Defaults handed to the top level
    localparam int unsigned          MAX_LEN_DEF = 4095;
    localparam logic [RADIX_W-1:0]   RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0]   RADIX_TEN   = 6'd10;
    localparam logic [RADIX_W-1:0]   RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0]   RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0]   NO_DIGIT    = 6'd36;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

    // Saturation limits
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BASE  = 2'd2
    } t_status;

    // Conversion phase
    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // Decoded character class
    typedef struct packed {
        logic               is_ws;
        logic               is_sign;
        logic               is_minus;
        logic [RADIX_W-1:0] digit;
    } t_char_info;

    // One result item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [CNT_W-1:0]   end_offset;
    } t_result;

endpackage

`default_nettype wire

/* design/asc2i_char_decode.sv */
`default_nettype none

module asc2i_char_decode
    import asc2i_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char,
    output t_char_info             o_info
);

    logic [CHAR_W-1:0] upper;

    // fold lower case onto upper case
    assign upper = (i_char >= CH_LO_A && i_char <= CH_LO_Z) ? (i_char - CASE_OFS) : i_char;

    always_comb begin
        // whitespace and sign classes (space is not whitespace here)
        o_info.is_ws    = (i_char == CH_FF) || (i_char == CH_LF) || (i_char == CH_CR)
                       || (i_char == CH_TAB) || (i_char == CH_VT);
        o_info.is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        o_info.is_minus = (i_char == CH_MINUS);

        // digit value, NO_DIGIT when not alphanumeric
        if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            o_info.digit = RADIX_W'(i_char - CH_ZERO);
        end else if (upper >= CH_UP_A && upper <= CH_UP_Z) begin
            o_info.digit = RADIX_W'(upper - CH_UP_A) + RADIX_TEN;
        end else begin
            o_info.digit = NO_DIGIT;
        end
    end

endmodule

`default_nettype wire

/* design/asc2i_core.sv */
`default_nettype none

module asc2i_core
    import asc2i_pkg::*;
#(
    parameter logic [CNT_W-1:0] CNT_CAP = 12'(MAX_LEN_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic               i_first,
    input  wire t_char_info         i_info,
    input  wire logic [RADIX_W-1:0] i_radix,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output t_result                 o_result
);

    localparam int unsigned PROD_W = VALUE_W + RADIX_W;

    t_phase             r_phase, n_phase, cur_phase;
    logic [VALUE_W-1:0] r_acc, n_acc, cur_acc;
    logic               r_neg, n_neg, cur_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt, cur_cnt, cnt_inc;
    logic               r_out_valid;
    t_result            r_result, n_result;
    logic               res_hit;

    logic [RADIX_W-1:0] base;
    logic               base_bad;
    logic [PROD_W-1:0]  prod_sum, limit;
    logic               over;

    // effective base
    assign base     = (i_radix == '0) ? RADIX_TEN : i_radix;
    assign base_bad = (base < RADIX_MIN) || (base > RADIX_MAX);

    // a start clears the conversion state before the character is applied
    assign cur_phase = i_first ? PH_LEAD : r_phase;
    assign cur_acc   = i_first ? '0 : r_acc;
    assign cur_neg   = i_first ? 1'b0 : r_neg;
    assign cur_cnt   = i_first ? '0 : r_cnt;
    assign cnt_inc   = (cur_cnt < CNT_CAP) ? (cur_cnt + 1'b1) : cur_cnt;

    // acc * base + digit, overflow when above the signed limit
    assign prod_sum = (PROD_W'(cur_acc) * PROD_W'(base)) + PROD_W'(i_info.digit);
    assign limit    = cur_neg ? PROD_W'(NEG_LIMIT) : PROD_W'(POS_LIMIT);
    assign over     = prod_sum > limit;

    // next state and result
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        res_hit  = 1'b0;
        n_result = '{value: '0, status: ST_OK, end_offset: '0};
        if (i_fire) begin
            n_phase = cur_phase;
            n_acc   = cur_acc;
            n_neg   = cur_neg;
            n_cnt   = cur_cnt;
            if (cur_phase != PH_DONE) begin
                priority if (base_bad) begin
                    res_hit  = 1'b1;
                    n_result = '{value: '0, status: ST_BASE, end_offset: '0};
                    n_phase  = PH_DONE;
                end else if (cur_phase == PH_LEAD && i_info.is_ws) begin
                    n_cnt = cnt_inc;
                end else if (cur_phase == PH_LEAD && i_info.is_sign) begin
                    n_neg   = i_info.is_minus;
                    n_cnt   = cnt_inc;
                    n_phase = PH_DIGITS;
                end else if (i_info.digit >= base) begin
                    res_hit  = 1'b1;
                    n_result = '{value: (cur_neg ? ('0 - cur_acc) : cur_acc),
                                 status: ST_OK, end_offset: cur_cnt};
                    n_phase  = PH_DONE;
                end else if (over) begin
                    res_hit  = 1'b1;
                    n_result = '{value: (cur_neg ? NEG_LIMIT : POS_LIMIT),
                                 status: ST_RANGE, end_offset: cur_cnt};
                    n_phase  = PH_DONE;
                end else begin
                    n_acc   = prod_sum[VALUE_W-1:0];
                    n_cnt   = cnt_inc;
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    // conversion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
        end
    end

    // result register; fires only when it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_out_valid <= res_hit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && res_hit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

/* design/ascii_to_int_parser.sv */
// Throughput: one character per cycle unless a held result is stalled at the output;
// input register, then one step of decode, multiply-add by the base and limit
// compare into the result register, which takes the character's result, if any.
// The input stalls only while a held result is stalled at the output.
// Reset (i_rst_n, synchronous, active low): radix 10, no conversion running.
`default_nettype none

module ascii_to_int_parser
    import asc2i_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [RADIX_W-1:0]        i_cfg_radix,
    // character input
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [CHAR_W-1:0]         i_char_code,
    input  wire logic                      i_first_char,
    // result output
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [VALUE_W-1:0]      o_value,
    output logic [1:0]                     o_status,
    output logic [CNT_W-1:0]               o_end_offset
);

    localparam logic [CNT_W-1:0] CNT_CAP = (MAX_LEN > 4095) ? 12'd4095 : CNT_W'(MAX_LEN);

    logic [RADIX_W-1:0] r_radix;
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_first;
    logic               fire;
    t_char_info         info;
    t_result            result;

    // radix register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    // input register; drains whenever the result register can take a transfer
    assign fire       = r_in_valid && !(o_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_char  <= i_char_code;
            r_first <= i_first_char;
        end
    end

    asc2i_char_decode u_decode (
        .i_char (r_char),
        .o_info (info)
    );

    asc2i_core #(
        .CNT_CAP (CNT_CAP)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_first     (r_first),
        .i_info      (info),
        .i_radix     (r_radix),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_value      = result.value;
    assign o_status     = result.status;
    assign o_end_offset = result.end_offset;

endmodule

`default_nettype wire
